// File: src/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared constants, command/status structs and the CRC-16 byte update for
// the framed-byte deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int PAYLOAD_DEPTH = 64;
  localparam int ADDR_W        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int LEN_W         = 7;

  localparam logic [7:0]  SYNC_FIRST  = 8'h39;
  localparam logic [7:0]  SYNC_SECOND = 8'h93;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  typedef struct packed {
    logic frame_start;
    logic cap_cmd;
    logic cap_len_hi;
    logic cap_len;
    logic data_wr;
    logic cap_crc_hi;
    logic res_err;
    logic res_empty;
    logic rd_start;
    logic rd_en;
    logic rd_next;
  } cfd_cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic len_zero;
    logic len_over;
    logic count_done;
    logic crc_match;
    logic count_zero;
    logic res_last;
  } cfd_sts_t;

  // CRC-16/MODBUS, reflected, one byte
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/cfd_in_if.sv
// ----------------------------------------------------------------------------
// cfd_in_if
// Received byte channel: valid/ready handshake, one byte per word.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: src/cfd_out_if.sv
// ----------------------------------------------------------------------------
// cfd_out_if
// Frame result channel: valid/ready handshake, one result per word.
// ----------------------------------------------------------------------------
interface cfd_out_if;
  logic       valid;
  logic       ready;
  logic       frame_status;
  logic [7:0] command_code;
  logic [6:0] payload_length;
  logic [7:0] data_byte;
  logic       has_data;
  logic       last_of_frame;

  modport source (output valid, output frame_status, output command_code,
                  output payload_length, output data_byte, output has_data,
                  output last_of_frame, input ready);
  modport sink   (input valid, input frame_status, input command_code,
                  input payload_length, input data_byte, input has_data,
                  input last_of_frame, output ready);
endinterface

// File: src/cfd_dp.sv
// ----------------------------------------------------------------------------
// cfd_dp
// Deframer datapath: header capture, payload buffer, running CRC, byte
// counter, drain pointer and result register.
// ----------------------------------------------------------------------------
module cfd_dp import cfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       rx_byte,
  input  cfd_cmd_t         cmd,
  output cfd_sts_t         sts,
  output logic             frame_status,
  output logic [7:0]       command_code,
  output logic [LEN_W-1:0] payload_length,
  output logic [7:0]       data_byte,
  output logic             has_data,
  output logic             last_of_frame
);

  logic [7:0]       held_command;
  logic [7:0]       length_high_byte;
  logic [LEN_W-1:0] expected_length;
  logic [LEN_W-1:0] byte_count;
  logic [7:0]       crc_high_byte;
  logic [15:0]      running_crc;
  logic [7:0]       payload_store [PAYLOAD_DEPTH];
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]       rd_data;
  logic             res_status;
  logic             res_has;
  logic             res_last;

  logic [15:0]      len16;
  logic [LEN_W-1:0] count_inc;

  assign len16     = {length_high_byte, rx_byte};
  assign count_inc = byte_count + LEN_W'(1);

  always_comb begin
    sts.is_sync1   = (rx_byte == SYNC_FIRST);
    sts.is_sync2   = (rx_byte == SYNC_SECOND);
    sts.len_zero   = (len16 == 16'd0);
    sts.len_over   = (len16 > 16'(PAYLOAD_DEPTH));
    sts.count_done = (count_inc >= expected_length);
    sts.crc_match  = ({crc_high_byte, rx_byte} == running_crc);
    sts.count_zero = (byte_count == '0);
    sts.res_last   = res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command     <= '0;
      length_high_byte <= '0;
      expected_length  <= '0;
      byte_count       <= '0;
      crc_high_byte    <= '0;
      running_crc      <= CRC_INIT;
    end else begin
      if (cmd.frame_start) begin
        held_command <= '0;
        byte_count   <= '0;
        running_crc  <= CRC_INIT;
      end
      if (cmd.cap_cmd) begin
        held_command <= rx_byte;
      end
      if (cmd.cap_len_hi) begin
        length_high_byte <= rx_byte;
      end
      if (cmd.cap_len) begin
        expected_length <= len16[LEN_W-1:0];
      end
      if (cmd.data_wr) begin
        byte_count  <= count_inc;
        running_crc <= crc16_update(running_crc, rx_byte);
      end
      if (cmd.cap_crc_hi) begin
        crc_high_byte <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_wr) begin
      payload_store[byte_count[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= payload_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
    if (cmd.res_err) begin
      res_status <= 1'b1;
      res_has    <= 1'b0;
      res_last   <= 1'b1;
    end else if (cmd.res_empty) begin
      res_status <= 1'b0;
      res_has    <= 1'b0;
      res_last   <= 1'b1;
    end else if (cmd.rd_en) begin
      res_status <= 1'b0;
      res_has    <= 1'b1;
      res_last   <= (LEN_W'(rd_idx) + LEN_W'(1) == byte_count);
    end
  end

  assign frame_status   = res_status;
  assign command_code   = held_command;
  assign payload_length = byte_count;
  assign data_byte      = res_has ? rd_data : 8'h00;
  assign has_data       = res_has;
  assign last_of_frame  = res_last;

endmodule

// File: src/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// cfd_ctrl
// Deframer controller: frame parse phases and result drain sequencing.
// ----------------------------------------------------------------------------
module cfd_ctrl import cfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cfd_sts_t sts,
  output cfd_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_HUNT,
    S_SYNC2,
    S_CMD,
    S_LEN_HI,
    S_LEN_LO,
    S_DATA,
    S_CRC_HI,
    S_CRC_LO,
    S_READ,
    S_SHOW
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    in_ready   = (state != S_READ) && (state != S_SHOW);
    out_valid  = (state == S_SHOW);
    accept     = in_valid && in_ready;
    cmd        = '0;
    state_next = state;
    case (state)
      S_HUNT: begin
        if (accept && sts.is_sync1) begin
          cmd.frame_start = 1'b1;
          state_next      = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (accept) begin
          state_next = sts.is_sync2 ? S_CMD : S_HUNT;
        end
      end
      S_CMD: begin
        if (accept) begin
          cmd.cap_cmd = 1'b1;
          state_next  = S_LEN_HI;
        end
      end
      S_LEN_HI: begin
        if (accept) begin
          cmd.cap_len_hi = 1'b1;
          state_next     = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (accept) begin
          if (sts.len_zero) begin
            cmd.cap_len = 1'b1;
            state_next  = S_CRC_HI;
          end else if (sts.len_over) begin
            state_next = S_HUNT;
          end else begin
            cmd.cap_len = 1'b1;
            state_next  = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.data_wr = 1'b1;
          if (sts.count_done) begin
            state_next = S_CRC_HI;
          end
        end
      end
      S_CRC_HI: begin
        if (accept) begin
          cmd.cap_crc_hi = 1'b1;
          state_next     = S_CRC_LO;
        end
      end
      S_CRC_LO: begin
        if (accept) begin
          if (!sts.crc_match) begin
            cmd.res_err = 1'b1;
            state_next  = S_SHOW;
          end else if (sts.count_zero) begin
            cmd.res_empty = 1'b1;
            state_next    = S_SHOW;
          end else begin
            cmd.rd_start = 1'b1;
            state_next   = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          if (sts.res_last) begin
            state_next = S_HUNT;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/crc16_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc16_frame_deframer
// Parses 0x39 0x93 CMD LEN_H LEN_L PAYLOAD CRC_H CRC_L frames from a byte
// stream, checks CRC-16/MODBUS over the payload and emits the payload bytes,
// an empty-frame word or a CRC error word.
//
//   port  dir  word           fields
//   rx    in   one rx byte    rx_byte
//   res   out  one result     frame_status, command_code, payload_length,
//                             data_byte, has_data, last_of_frame
//
// One received byte per cycle while rx.ready is high; the CRC is updated
// a whole byte at a time. After the last CRC byte of a good frame the
// payload drains word by word (registered memory read, then held on res
// until taken). rx.ready is low while results are pending. Synchronous
// reset returns to sync hunt; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
module crc16_frame_deframer import cfd_pkg::*; (
  input logic        clk,
  input logic        rst,
  cfd_in_if.sink     rx,
  cfd_out_if.source  res
);

  cfd_cmd_t cmd;
  cfd_sts_t sts;

  cfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx.rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .frame_status   (res.frame_status),
    .command_code   (res.command_code),
    .payload_length (res.payload_length),
    .data_byte      (res.data_byte),
    .has_data       (res.has_data),
    .last_of_frame  (res.last_of_frame)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rx.ready && res.valid))
    else $error("input accepted while a result is pending");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.has_data |-> res.last_of_frame && res.data_byte == 8'h00)
    else $error("dataless result not final or carries data");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_status |-> !res.has_data)
    else $error("error result carries data");

  a_resume_after_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.last_of_frame |=> rx.ready && !res.valid)
    else $error("input not resumed after final result");

endmodule
